// File: hw/rtl/ghash_pkg.sv
// Shared types and constants for the GHASH accumulator.
package ghash_pkg;

	localparam int unsigned BLOCK_BITS = 128;
	localparam int unsigned HALF_BITS  = 64;
	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned COUNT_BITS = 5;
	localparam int unsigned CFG_INDEX_BITS = 1;

	// Reduction constant folded into the top byte in the bit-reflected field.
	localparam logic [7:0] REDUCE_POLY = 8'he1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SUBKEY_HIGH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SUBKEY_LOW  = 1'b1;

	typedef struct packed {
		logic [HALF_BITS-1:0]  block_high;
		logic [HALF_BITS-1:0]  block_low;
		logic [COUNT_BITS-1:0] valid_bytes;
		logic                  restart;
	} in_word_t;

	typedef struct packed {
		logic [HALF_BITS-1:0] hash_high;
		logic [HALF_BITS-1:0] hash_low;
	} out_word_t;

	// Input stage contents handed to the multiplier core.
	typedef struct packed {
		logic [BLOCK_BITS-1:0] block;
		logic                  restart;
		logic                  empty;
	} stage_t;

endpackage

// File: hw/rtl/ghash_in_stage.sv
// Input register stage: masks unused bytes and holds one word for the core.
module ghash_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  ghash_pkg::in_word_t in_word,
	input  logic                advance,
	output logic                valid_s1,
	output ghash_pkg::stage_t   stage_s1
);
	import ghash_pkg::*;

	logic [BLOCK_BITS-1:0] full_block;
	logic [BLOCK_BITS-1:0] masked;

	assign full_block = {in_word.block_high, in_word.block_low};

	// Byte 0 sits in the top bits; a byte is kept when its position is below the count.
	for (genvar b = 0; b < BLOCK_BYTES; b++) begin : g_mask
		assign masked[BLOCK_BITS-1-8*b -: 8] =
			(in_word.valid_bytes > COUNT_BITS'(b)) ? full_block[BLOCK_BITS-1-8*b -: 8] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			stage_s1.block   <= masked;
			stage_s1.restart <= in_word.restart;
			stage_s1.empty   <= (in_word.valid_bytes == '0);
		end
	end

endmodule

// File: hw/rtl/ghash_core.sv
// Subkey registers, subkey power table and the accumulating GF(2^128) multiply.
module ghash_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [ghash_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [ghash_pkg::HALF_BITS-1:0]         cfg_data,
	input  ghash_pkg::stage_t                       stage_s1,
	input  logic                                    advance,
	output logic                                    busy,
	output logic [ghash_pkg::BLOCK_BITS-1:0]        acc_next
);
	import ghash_pkg::*;

	localparam int unsigned SWEEP_BITS = $clog2(BLOCK_BITS);

	logic [HALF_BITS-1:0]  subkey_high_q;
	logic [HALF_BITS-1:0]  subkey_low_q;
	logic [BLOCK_BITS-1:0] new_key;
	logic                  busy_q;
	logic [SWEEP_BITS-1:0] sweep_cnt_q;
	logic [BLOCK_BITS-1:0] v_q;
	logic [BLOCK_BITS-1:0] row_q [BLOCK_BITS];
	logic [BLOCK_BITS-1:0] acc_q;
	logic [BLOCK_BITS-1:0] base;
	logic [BLOCK_BITS-1:0] x;
	logic [BLOCK_BITS-1:0] prod;

	// Multiply by x in the bit-reflected field: shift toward bit 0 and fold the carry.
	function automatic logic [BLOCK_BITS-1:0] mul_x(input logic [BLOCK_BITS-1:0] v);
		logic [BLOCK_BITS-1:0] r;
		r = v >> 1;
		if (v[0]) begin
			r[BLOCK_BITS-1 -: 8] = r[BLOCK_BITS-1 -: 8] ^ REDUCE_POLY;
		end
		return r;
	endfunction

	always_comb begin
		new_key = {subkey_high_q, subkey_low_q};
		if (cfg_index == CFG_SUBKEY_HIGH) begin
			new_key[BLOCK_BITS-1 -: HALF_BITS] = cfg_data;
		end else begin
			new_key[HALF_BITS-1:0] = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkey_high_q <= '0;
			subkey_low_q  <= '0;
		end else if (cfg_we) begin
			subkey_high_q <= new_key[BLOCK_BITS-1 -: HALF_BITS];
			subkey_low_q  <= new_key[HALF_BITS-1:0];
		end
	end

	// Each subkey write (and reset) rebuilds the table of H times x^i, one row a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			sweep_cnt_q <= '0;
			v_q         <= '0;
		end else if (cfg_we) begin
			busy_q      <= 1'b1;
			sweep_cnt_q <= '0;
			v_q         <= new_key;
		end else if (busy_q) begin
			v_q         <= mul_x(v_q);
			sweep_cnt_q <= sweep_cnt_q + SWEEP_BITS'(1);
			if (sweep_cnt_q == SWEEP_BITS'(BLOCK_BITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift line: after a full sweep, row i holds H times x^i.
	always_ff @(posedge clk) begin
		if (busy_q && !cfg_we) begin
			for (int k = 0; k < BLOCK_BITS - 1; k++) begin
				row_q[k] <= row_q[k+1];
			end
			row_q[BLOCK_BITS-1] <= v_q;
		end
	end

	assign busy = busy_q;

	assign base = stage_s1.restart ? '0 : acc_q;
	assign x    = base ^ stage_s1.block;

	// Bit i of the field element is bit 127-i of the vector.
	always_comb begin
		prod = '0;
		for (int i = 0; i < BLOCK_BITS; i++) begin
			prod = prod ^ (row_q[i] & {BLOCK_BITS{x[BLOCK_BITS-1-i]}});
		end
	end

	assign acc_next = stage_s1.empty ? base : prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (advance) begin
			acc_q <= acc_next;
		end
	end

endmodule

// File: hw/rtl/ghash_out_buf.sv
// Two-entry result buffer that decouples the output stall from the input side.
module ghash_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ghash_pkg::out_word_t  push_word,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ghash_pkg::out_word_t  out_word
);
	import ghash_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_BITS = $clog2(DEPTH);
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

	out_word_t             buf_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign room      = (count_q != CNT_BITS'(DEPTH));
	assign pop       = out_valid && !out_stall;
	assign out_word  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// File: hw/rtl/ghash_gf128_accumulator.sv
// GHASH accumulator top level: one 128-bit word per cycle while in_stall is low.
// A word accepted into the input stage has its result written to the result buffer once that buffer has room.
// Throughput: one word per cycle, set by the combinational multiply against the H power table;
// in_stall also rises while the two-word result buffer is full and the input stage holds a word.
// Reset clears the subkey and accumulator and rebuilds the table, with in_stall high until the sweep ends.
// Every subkey write starts the same table rebuild.
module ghash_gf128_accumulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ghash_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ghash_pkg::HALF_BITS-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ghash_pkg::in_word_t                  in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ghash_pkg::out_word_t                 out_word
);
	import ghash_pkg::*;

	logic                  valid_s1;
	stage_t                stage_s1;
	logic                  room;
	logic                  advance;
	logic                  take;
	logic                  busy;
	logic [BLOCK_BITS-1:0] acc_next;
	out_word_t             result;

	assign advance  = valid_s1 && room;
	assign in_stall = busy || (valid_s1 && !room);
	assign take     = in_valid && !in_stall;

	assign result.hash_high = acc_next[BLOCK_BITS-1 -: HALF_BITS];
	assign result.hash_low  = acc_next[HALF_BITS-1:0];

	ghash_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_word  (in_word),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1)
	);

	ghash_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stage_s1  (stage_s1),
		.advance   (advance),
		.busy      (busy),
		.acc_next  (acc_next)
	);

	ghash_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_word (result),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the GHASH GF(2^128) accumulator.
`timescale 1ns / 100ps

module tb_top;
	import ghash_pkg::*;

	typedef struct {
		bit                    load_key;
		logic [BLOCK_BITS-1:0] key;
		in_word_t              w;
		bit                    pinned;
		logic [BLOCK_BITS-1:0] want;
	} dir_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_SUBKEY_HIGH;
	logic [HALF_BITS-1:0]      cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	in_word_t                  in_word = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	out_word_t                 out_word;

	logic [BLOCK_BITS-1:0] subkey = '0;
	logic [BLOCK_BITS-1:0] hash_acc = '0;
	out_word_t             expected_hashes[$];
	out_word_t             head_hash;
	dir_row_t              dir_rows[$];
	int unsigned           burst_left = 8;
	int unsigned           stall_mode = 0;
	int unsigned           stall_tick = 0;
	int unsigned           words_sent = 0;
	int unsigned           hashes_checked = 0;
	int unsigned           keys_loaded = 0;
	int unsigned           mismatches = 0;

	localparam logic [BLOCK_BITS-1:0] ONES = {BLOCK_BITS{1'b1}};
	// In the bit-reflected field the multiplicative identity is the MSB of byte 0.
	localparam logic [BLOCK_BITS-1:0] GF_ONE = {1'b1, {(BLOCK_BITS-1){1'b0}}};

	ghash_gf128_accumulator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	always #5 clk = ~clk;

	// Folds one word into the running hash and returns the new accumulator.
	function automatic out_word_t absorb_word(in_word_t w);
		logic [BLOCK_BITS-1:0] mask;
		logic [BLOCK_BITS-1:0] x;
		logic [BLOCK_BITS-1:0] v;
		logic [BLOCK_BITS-1:0] prod;
		int unsigned           nb;
		logic                  carry;
		nb = (w.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : w.valid_bytes;
		if (w.restart)
			hash_acc = '0;
		if (nb != 0) begin
			mask = ~(ONES >> (8 * nb));
			x = hash_acc ^ ({w.block_high, w.block_low} & mask);
			v = subkey;
			prod = '0;
			for (int i = 0; i < BLOCK_BITS; i++) begin
				if (x[BLOCK_BITS-1-i])
					prod ^= v;
				carry = v[0];
				v = v >> 1;
				if (carry)
					v[BLOCK_BITS-1 -: 8] ^= REDUCE_POLY;
			end
			hash_acc = prod;
		end
		return hash_acc;
	endfunction

	function automatic dir_row_t mk_row(int unsigned ld, logic [BLOCK_BITS-1:0] key,
			logic [BLOCK_BITS-1:0] blk, int unsigned vb, int unsigned rs,
			int unsigned pinned, logic [BLOCK_BITS-1:0] want);
		dir_row_t r;
		r.load_key = (ld != 0);
		r.key = key;
		r.w.block_high = blk[BLOCK_BITS-1:HALF_BITS];
		r.w.block_low = blk[HALF_BITS-1:0];
		r.w.valid_bytes = COUNT_BITS'(vb);
		r.w.restart = (rs != 0);
		r.pinned = (pinned != 0);
		r.want = want;
		return r;
	endfunction

	task automatic drive_word(in_word_t w, bit pinned, logic [BLOCK_BITS-1:0] want);
		out_word_t predicted;
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = absorb_word(w);
		expected_hashes.push_back(pinned ? out_word_t'(want) : predicted);
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [HALF_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		// Each write kicks off a table rebuild that holds the input side off.
		repeat (2) @(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Subkey changes only once the pipeline has drained.
	task automatic load_subkey(logic [BLOCK_BITS-1:0] key);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(CFG_SUBKEY_HIGH, key[BLOCK_BITS-1:HALF_BITS]);
		write_reg(CFG_SUBKEY_LOW, key[HALF_BITS-1:0]);
		subkey = key;
		keys_loaded++;
	endtask

	// The receiver switches between free running, light, heavy and periodic stalls.
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 256 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 1);
			default: out_stall <= (stall_tick % 8 < 5);
		endcase
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_hashes.size() == 0) begin
				mismatches++;
				$display("%0t unexpected hash word: expected none, actual %h", $time, out_word);
			end else begin
				head_hash = expected_hashes.pop_front();
				hashes_checked++;
				if (out_word.hash_high !== head_hash.hash_high) begin
					mismatches++;
					$display("%0t hash_high mismatch: expected %h, actual %h", $time,
						head_hash.hash_high, out_word.hash_high);
				end
				if (out_word.hash_low !== head_hash.hash_low) begin
					mismatches++;
					$display("%0t hash_low mismatch: expected %h, actual %h", $time,
						head_hash.hash_low, out_word.hash_low);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [BLOCK_BITS-1:0] keys[6];
		in_word_t              w;
		int unsigned           pick;
		keys[0] = ONES;
		keys[1] = GF_ONE;
		keys[2] = '0;
		keys[3] = {$urandom, $urandom, $urandom, $urandom};
		keys[4] = {$urandom, $urandom, $urandom, $urandom};
		keys[5] = {$urandom, $urandom, $urandom, $urandom};

		// The subkey is zero out of reset, so every product is zero.
		dir_rows.push_back(mk_row(0, '0, ONES, 16, 1, 1, '0));
		dir_rows.push_back(mk_row(0, '0, ONES, 16, 0, 1, '0));
		// With H as the field identity the hash is just the XOR of the masked blocks.
		dir_rows.push_back(mk_row(1, GF_ONE, ONES, 16, 1, 1, ONES));
		dir_rows.push_back(mk_row(0, '0, '0, 16, 0, 1, ONES));
		dir_rows.push_back(mk_row(0, '0, ONES, 0, 0, 1, ONES));
		dir_rows.push_back(mk_row(0, '0, ONES, 0, 1, 1, '0));
		dir_rows.push_back(mk_row(0, '0, ONES, 1, 1, 1, {8'hff, 120'h0}));
		dir_rows.push_back(mk_row(0, '0, ONES, 8, 1, 1, {64'hffffffffffffffff, 64'h0}));
		dir_rows.push_back(mk_row(0, '0, ONES, 9, 1, 1, {72'hffffffffffffffffff, 56'h0}));
		dir_rows.push_back(mk_row(0, '0, ONES, 15, 1, 1, {{120{1'b1}}, 8'h00}));
		dir_rows.push_back(mk_row(0, '0, ONES, 17, 1, 1, ONES));
		dir_rows.push_back(mk_row(0, '0, ONES, 31, 1, 1, ONES));
		dir_rows.push_back(mk_row(0, '0, {64{2'b10}}, 16, 1, 1, {64{2'b10}}));
		dir_rows.push_back(mk_row(0, '0, {64{2'b01}}, 16, 0, 1, ONES));
		// All-ones subkey: the identity block returns H itself.
		dir_rows.push_back(mk_row(1, ONES, GF_ONE, 16, 1, 1, ONES));
		dir_rows.push_back(mk_row(0, '0, ONES, 16, 0, 0, '0));
		dir_rows.push_back(mk_row(0, '0, ONES, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(0, '0, 128'h1, 16, 1, 0, '0));
		// Lowest-order subkey bit forces the reduction on the very first step.
		dir_rows.push_back(mk_row(1, 128'h1, 128'h1, 16, 1, 0, '0));
		dir_rows.push_back(mk_row(0, '0, ONES, 12, 0, 0, '0));
		dir_rows.push_back(mk_row(0, '0, 128'h0123456789abcdef_fedcba9876543210, 16, 0, 0, '0));

		in_valid <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].load_key)
				load_subkey(dir_rows[i].key);
			drive_word(dir_rows[i].w, dir_rows[i].pinned, dir_rows[i].want);
		end

		// Random messages: mostly full blocks, with partial tails, empty and oversized counts.
		for (int p = 0; p < 6; p++) begin
			load_subkey(keys[p]);
			for (int n = 0; n < 200; n++) begin
				pick = $urandom_range(0, 19);
				w.block_high = {$urandom, $urandom};
				w.block_low = {$urandom, $urandom};
				if (pick == 0)
					w.block_high = '1;
				else if (pick == 1)
					w.block_low = '0;
				pick = $urandom_range(0, 19);
				if (pick < 12)
					w.valid_bytes = COUNT_BITS'(BLOCK_BYTES);
				else if (pick < 17)
					w.valid_bytes = COUNT_BITS'($urandom_range(1, BLOCK_BYTES - 1));
				else if (pick < 18)
					w.valid_bytes = '0;
				else
					w.valid_bytes = COUNT_BITS'($urandom_range(BLOCK_BYTES + 1, 31));
				w.restart = ($urandom_range(0, 7) == 0);
				drive_word(w, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_hashes.size() != 0)
			mismatches++;

		$display("Sent %0d words under %0d subkey settings; %0d hashes compared.",
			words_sent, keys_loaded + 1, hashes_checked);
		$display("Counts 0 to 31, restarts, partial tails and receiver stalls were all exercised.");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
